### rtl/dlsq_pkg.sv
// Shared constants for the delta-list sleep queue.
`default_nettype none

package dlsq_pkg;

	localparam int ID_W      = 16;
	localparam int IN_TICK_W = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic STATUS_WOKEN    = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

endpackage

`default_nettype wire

### rtl/dlsq_in_if.sv
// Command channel: insert or tick requests.
`default_nettype none

interface dlsq_in_if import dlsq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [ID_W-1:0]      thread_id;
	logic [IN_TICK_W-1:0] sleep_ticks;

	modport source (output valid, output command, output thread_id, output sleep_ticks,
		input ready);
	modport sink (input valid, input command, input thread_id, input sleep_ticks,
		output ready);
endinterface

`default_nettype wire

### rtl/dlsq_out_if.sv
// Result channel: woken or rejected threads.
`default_nettype none

interface dlsq_out_if import dlsq_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] thread_id_out;
	logic            status;
	logic            last;

	modport source (output valid, output thread_id_out, output status, output last,
		input ready);
	modport sink (input valid, input thread_id_out, input status, input last,
		output ready);
endinterface

`default_nettype wire

### rtl/dlsq_ram.sv
// Generic one-write, one-read RAM with registered read data.
`default_nettype none

module dlsq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/dlsq_front.sv
// Front end: accepts commands, normalizes the sleep time, buffers two commands.
`default_nettype none

module dlsq_front import dlsq_pkg::*; #(
	parameter int TICK_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	dlsq_in_if.sink                   cmd_ch,
	output logic                      q_valid,
	input  wire logic                 q_ready,
	output logic                      q_cmd,
	output logic     [ID_W-1:0]       q_id,
	output logic     [TICK_BITS-1:0]  q_rem
);

	localparam logic [1:0] QFULL = 2'd2;

	logic [TICK_BITS-1:0] sat;
	logic [TICK_BITS-1:0] rem;
	logic                 push;
	logic                 pop;

	logic                 cmd_q [2];
	logic [ID_W-1:0]      id_q  [2];
	logic [TICK_BITS-1:0] rem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;

	// saturate to the tick width when it is narrower than the input
	generate
		if (TICK_BITS >= IN_TICK_W) begin : g_wide
			assign sat = TICK_BITS'(cmd_ch.sleep_ticks);
		end else begin : g_narrow
			assign sat = (|cmd_ch.sleep_ticks[IN_TICK_W-1:TICK_BITS]) ? '1
				: cmd_ch.sleep_ticks[TICK_BITS-1:0];
		end
	endgenerate

	// a zero sleep counts as one tick
	assign rem = (sat == '0) ? TICK_BITS'(1) : sat;

	assign cmd_ch.ready = (fill_q != QFULL);
	assign push         = cmd_ch.valid && cmd_ch.ready;
	assign q_valid      = (fill_q != 2'd0);
	assign pop          = q_valid && q_ready;

	assign q_cmd = cmd_q[rd_ptr_q];
	assign q_id  = id_q[rd_ptr_q];
	assign q_rem = rem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= cmd_ch.command;
			id_q[wr_ptr_q]  <= cmd_ch.thread_id;
			rem_q[wr_ptr_q] <= rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/dlsq_back.sv
// Back end: sequencer that walks, shifts and pops the delta list held in RAM.
`default_nettype none

module dlsq_back import dlsq_pkg::*; #(
	parameter int MAX_SLEEPERS = 16,
	parameter int TICK_BITS    = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	output logic                      q_ready,
	input  wire logic                 q_cmd,
	input  wire logic [ID_W-1:0]      q_id,
	input  wire logic [TICK_BITS-1:0] q_rem,
	dlsq_out_if.source                res_ch
);

	localparam int IW = $clog2(MAX_SLEEPERS);
	localparam int CW = $clog2(MAX_SLEEPERS + 1);
	localparam int DW = ID_W + TICK_BITS;

	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_SLEEPERS);
	localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(MAX_SLEEPERS);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_TK_DEC  = 3'd1;
	localparam logic [2:0] ST_TK_CHK  = 3'd2;
	localparam logic [2:0] ST_EMIT    = 3'd3;
	localparam logic [2:0] ST_IN_CMP  = 3'd4;
	localparam logic [2:0] ST_SH      = 3'd5;
	localparam logic [2:0] ST_WR_SUCC = 3'd6;
	localparam logic [2:0] ST_WR_NEW  = 3'd7;

	// list position relative to the head -> RAM address
	function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
		input logic [IW-1:0] off);
		logic [IW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[IW-1:0];
	endfunction

	logic [2:0]           state_q, state_d;
	logic [IW-1:0]        head_q, head_d;
	logic [CW-1:0]        count_q, count_d;
	logic [TICK_BITS-1:0] rem_q, rem_d;
	logic [ID_W-1:0]      id_q, id_d;
	logic [IW-1:0]        k_q, k_d;
	logic [IW-1:0]        j_q, j_d;
	logic [ID_W-1:0]      succ_id_q, succ_id_d;
	logic [TICK_BITS-1:0] succ_delta_q, succ_delta_d;
	logic [ID_W-1:0]      pend_id_q, pend_id_d;
	logic                 pend_st_q, pend_st_d;

	logic                 res_valid_q;
	logic [ID_W-1:0]      res_id_q;
	logic                 res_st_q;
	logic                 res_last_q;

	logic [IW-1:0]        rd_off;
	logic [IW-1:0]        wr_off;
	logic                 we;
	logic [DW-1:0]        wdata;
	logic [DW-1:0]        rdata;
	logic [TICK_BITS-1:0] rd_delta;
	logic [ID_W-1:0]      rd_id;
	logic [TICK_BITS-1:0] dec;
	logic                 out_free;
	logic                 emit;
	logic                 emit_last;

	assign rd_delta = rdata[TICK_BITS-1:0];
	assign rd_id    = rdata[DW-1:TICK_BITS];
	assign dec      = (rd_delta == '0) ? '0 : rd_delta - TICK_BITS'(1);
	assign out_free = !res_valid_q || res_ch.ready;

	dlsq_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_SLEEPERS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(wrap(head_q, wr_off)),
		.wdata(wdata),
		.raddr(wrap(head_q, rd_off)),
		.rdata(rdata)
	);

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		rem_d        = rem_q;
		id_d         = id_q;
		k_d          = k_q;
		j_d          = j_q;
		succ_id_d    = succ_id_q;
		succ_delta_d = succ_delta_q;
		pend_id_d    = pend_id_q;
		pend_st_d    = pend_st_q;
		rd_off       = '0;
		wr_off       = '0;
		we           = 1'b0;
		wdata        = '0;
		emit         = 1'b0;
		emit_last    = 1'b0;
		q_ready      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					id_d  = q_id;
					rem_d = q_rem;
					k_d   = '0;
					if (q_cmd == CMD_TICK) begin
						if (count_q != '0) begin
							state_d = ST_TK_DEC;
						end
					end else if (count_q == CNT_FULL) begin
						pend_id_d = q_id;
						pend_st_d = STATUS_REJECTED;
						state_d   = ST_EMIT;
					end else if (count_q == '0) begin
						state_d = ST_WR_NEW;
					end else begin
						state_d = ST_IN_CMP;
					end
				end
			end
			ST_TK_DEC: begin
				if (dec != '0) begin
					we      = 1'b1;
					wdata   = {rd_id, dec};
					state_d = ST_IDLE;
				end else begin
					// head wakes; hold it until we know whether it is the last
					pend_id_d = rd_id;
					pend_st_d = STATUS_WOKEN;
					head_d    = wrap(head_q, IW'(1));
					count_d   = count_q - CW'(1);
					rd_off    = IW'(1);
					state_d   = (count_q == CW'(1)) ? ST_EMIT : ST_TK_CHK;
				end
			end
			ST_TK_CHK: begin
				if (out_free) begin
					emit = 1'b1;
					if (rd_delta == '0) begin
						pend_id_d = rd_id;
						head_d    = wrap(head_q, IW'(1));
						count_d   = count_q - CW'(1);
						rd_off    = IW'(1);
						if (count_q == CW'(1)) begin
							state_d = ST_EMIT;
						end
					end else begin
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_IN_CMP: begin
				if (rem_q > rd_delta) begin
					rem_d = rem_q - rd_delta;
					if (CW'(k_q) + CW'(1) < count_q) begin
						k_d    = k_q + IW'(1);
						rd_off = k_q + IW'(1);
					end else begin
						k_d     = IW'(count_q);
						state_d = ST_WR_NEW;
					end
				end else begin
					succ_id_d    = rd_id;
					succ_delta_d = rd_delta - rem_q;
					if (count_q - CW'(1) > CW'(k_q)) begin
						j_d     = IW'(count_q - CW'(1));
						rd_off  = IW'(count_q - CW'(1));
						state_d = ST_SH;
					end else begin
						state_d = ST_WR_SUCC;
					end
				end
			end
			ST_SH: begin
				// move entry j one place toward the tail, fetch j-1
				we     = 1'b1;
				wr_off = j_q + IW'(1);
				wdata  = rdata;
				if (j_q - IW'(1) > k_q) begin
					j_d    = j_q - IW'(1);
					rd_off = j_q - IW'(1);
				end else begin
					state_d = ST_WR_SUCC;
				end
			end
			ST_WR_SUCC: begin
				we      = 1'b1;
				wr_off  = k_q + IW'(1);
				wdata   = {succ_id_q, succ_delta_q};
				state_d = ST_WR_NEW;
			end
			ST_WR_NEW: begin
				we      = 1'b1;
				wr_off  = k_q;
				wdata   = {id_q, rem_q};
				count_d = count_q + CW'(1);
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_q        <= rem_d;
		id_q         <= id_d;
		k_q          <= k_d;
		j_q          <= j_d;
		succ_id_q    <= succ_id_d;
		succ_delta_q <= succ_delta_d;
		pend_id_q    <= pend_id_d;
		pend_st_q    <= pend_st_d;
		if (emit) begin
			res_id_q   <= pend_id_q;
			res_st_q   <= pend_st_q;
			res_last_q <= emit_last;
		end
	end

	assign res_ch.valid         = res_valid_q;
	assign res_ch.thread_id_out = res_id_q;
	assign res_ch.status        = res_st_q;
	assign res_ch.last          = res_last_q;

endmodule

`default_nettype wire

### rtl/delta_list_sleep_queue.sv
// Top level of the delta-list sleep queue.
`default_nettype none

// Sleep queue kept as a delta list in a single RAM used as a ring. Commands
// enter a two-beat queue, so the command side keeps moving while the list
// sequencer works, until two commands wait. An insert does the accept, one
// RAM read per entry walked past, one move per entry shifted toward the tail,
// a successor delta write if the new entry lands before one, and the new
// entry's write. A tick lowers the head's delta and wakes each thread at the
// front whose delta is then zero; an insert into a full queue returns its
// thread id with status rejected. Results wait in an output register, one
// beat each, the last of a command marked by last; a stalled result side holds the sequencer.
module delta_list_sleep_queue import dlsq_pkg::*; #(
	parameter int MAX_SLEEPERS = 16,
	parameter int TICK_BITS    = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	dlsq_in_if.sink    cmd_ch,
	dlsq_out_if.source res_ch
);

	logic                 q_valid;
	logic                 q_ready;
	logic                 q_cmd;
	logic [ID_W-1:0]      q_id;
	logic [TICK_BITS-1:0] q_rem;

	dlsq_front #(
		.TICK_BITS(TICK_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_cmd  (q_cmd),
		.q_id   (q_id),
		.q_rem  (q_rem)
	);

	dlsq_back #(
		.MAX_SLEEPERS(MAX_SLEEPERS),
		.TICK_BITS   (TICK_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_cmd  (q_cmd),
		.q_id   (q_id),
		.q_rem  (q_rem),
		.res_ch (res_ch)
	);

endmodule

`default_nettype wire
